FILE: rtl/dsm_pkg.sv
package dsm_pkg;

    localparam int NUM_VOICES     = 3;
    localparam int LEVEL_W        = 12;
    localparam int POS_W          = 15;
    localparam int LEN_W          = 16;
    localparam int CMD_W          = 16;
    localparam int SUM_W          = 14;
    localparam int VOICE_DEPTH_DEF = 32768;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 12'd4095;
    localparam logic [LEVEL_W-1:0] LEVEL_MASK = 12'h0FFF;
    localparam logic [LEN_W-1:0]   POS_LIMIT = 16'd32768;
    localparam logic [CMD_W-1:0]   CMD_BITS  = 16'((1 << 14) | (1 << 13) | (1 << 12));

    localparam logic [LEN_W-1:0] KICK_LEN_RST  = 16'd16848;
    localparam logic [LEN_W-1:0] SNARE_LEN_RST = 16'd800;
    localparam logic [LEN_W-1:0] HIHAT_LEN_RST = 16'd500;

    typedef enum logic [1:0] {
        OP_POLL = 2'd0,
        OP_TICK = 2'd1,
        OP_LOAD = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_KICK_LEN  = 2'd0,
        CFG_SNARE_LEN = 2'd1,
        CFG_HIHAT_LEN = 2'd2
    } t_cfg_index;

endpackage

FILE: rtl/dsm_ram.sv
module dsm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32768,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/drum_sample_mixer.sv
// Three one-shot drum voices (kick, snare, hi-hat) played from 12-bit sample RAMs
// and mixed into one DAC command word per tick item. Opcode 0 polls the active-low
// buttons (a new press restarts that voice), 1 is a sample tick that returns one
// result, 2 writes a sample word into the RAM of the selected voice. One item is
// accepted every cycle while the output is not stalled; a tick result passes the
// registered read of the sample RAMs, then the mix and saturation into the output
// register. Sample RAM contents are undefined until loaded, and the voice lengths
// may only be changed while no tick result is pending.
module drum_sample_mixer #(
    parameter int VOICE_DEPTH = dsm_pkg::VOICE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_button_levels,
    input  logic [1:0]  i_voice,
    input  logic [14:0] i_load_address,
    input  logic [11:0] i_load_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_dac_command,
    output logic        o_clipped,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int NV = dsm_pkg::NUM_VOICES;
    localparam int AW = $clog2(VOICE_DEPTH);

    logic [dsm_pkg::LEN_W-1:0]   r_len [NV];
    logic [dsm_pkg::POS_W-1:0]   r_pos [NV];
    logic [dsm_pkg::POS_W-1:0]   n_pos [NV];
    logic [NV-1:0]               r_active, n_active;
    logic [NV-1:0]               r_prev, n_prev;
    logic                        r_s1_valid, n_s1_valid;
    logic [NV-1:0]               r_s1_use, n_s1_use;
    logic                        r_out_valid;
    logic [15:0]                 r_dac;
    logic                        r_clip;

    logic [dsm_pkg::LEN_W-1:0]   len_eff [NV];
    logic [15:0]                 pos_ext [NV];
    logic [15:0]                 pos_inc [NV];
    logic [NV-1:0]               play;
    logic [NV-1:0]               in_depth;
    logic [NV-1:0]               ram_re;
    logic [NV-1:0]               ram_we;
    logic [AW-1:0]               ram_raddr [NV];
    logic [AW-1:0]               ram_waddr;
    logic [15:0]                 load_addr_ext;
    logic [dsm_pkg::LEVEL_W-1:0] ram_rdata [NV];

    logic                        in_xfer;
    logic                        s1_adv;
    logic [NV-1:0]               pressed;
    logic [NV-1:0]               fresh;
    logic [dsm_pkg::SUM_W-1:0]   mix;
    logic                        mix_clip;
    logic [dsm_pkg::LEVEL_W-1:0] mix_level;

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign load_addr_ext = {1'b0, i_load_address};
    assign ram_waddr     = load_addr_ext[AW-1:0];
    assign pressed       = ~i_button_levels;
    assign fresh         = pressed & ~r_prev;

    always_comb begin
        for (int v = 0; v < NV; v++) begin
            len_eff[v]  = (r_len[v] > dsm_pkg::POS_LIMIT) ? dsm_pkg::POS_LIMIT : r_len[v];
            pos_ext[v]  = {1'b0, r_pos[v]};
            pos_inc[v]  = pos_ext[v] + 16'd1;
            play[v]     = r_active[v] && (pos_ext[v] < len_eff[v]);
            in_depth[v] = ({1'b0, pos_ext[v]} < 17'(VOICE_DEPTH));
            ram_raddr[v] = pos_ext[v][AW-1:0];
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_active = r_active;
        n_prev   = r_prev;
        n_s1_use = r_s1_use;
        ram_re   = '0;
        ram_we   = '0;
        n_s1_valid = r_s1_valid && !s1_adv;
        if (in_xfer) begin
            case (dsm_pkg::t_opcode'(i_opcode))
                dsm_pkg::OP_POLL: begin
                    for (int v = 0; v < NV; v++) begin
                        if (fresh[v]) begin
                            n_pos[v]    = '0;
                            n_active[v] = 1'b1;
                        end
                    end
                    n_prev = pressed;
                end
                dsm_pkg::OP_TICK: begin
                    n_s1_valid = 1'b1;
                    for (int v = 0; v < NV; v++) begin
                        n_s1_use[v] = play[v] && in_depth[v];
                        ram_re[v]   = play[v] && in_depth[v];
                        if (play[v]) begin
                            if (pos_inc[v] >= len_eff[v]) begin
                                n_active[v] = 1'b0;
                                n_pos[v]    = '0;
                            end else begin
                                n_pos[v] = pos_inc[v][dsm_pkg::POS_W-1:0];
                            end
                        end
                    end
                end
                dsm_pkg::OP_LOAD: begin
                    for (int v = 0; v < NV; v++) begin
                        ram_we[v] = (i_voice == 2'(v))
                            && ({1'b0, load_addr_ext} < 17'(VOICE_DEPTH));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < NV; g++) begin : g_store
        dsm_ram #(
            .WIDTH (dsm_pkg::LEVEL_W),
            .DEPTH (VOICE_DEPTH)
        ) u_store (
            .i_clk   (i_clk),
            .i_we    (ram_we[g]),
            .i_waddr (ram_waddr),
            .i_wdata (i_load_value & dsm_pkg::LEVEL_MASK),
            .i_re    (ram_re[g]),
            .i_raddr (ram_raddr[g]),
            .o_rdata (ram_rdata[g])
        );
    end

    always_comb begin
        mix = '0;
        for (int v = 0; v < NV; v++) begin
            if (r_s1_use[v]) begin
                mix = mix + dsm_pkg::SUM_W'(ram_rdata[v]);
            end
        end
        mix_clip  = (mix > dsm_pkg::SUM_W'(dsm_pkg::MAX_LEVEL));
        mix_level = mix_clip ? dsm_pkg::MAX_LEVEL : mix[dsm_pkg::LEVEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len[0]    <= dsm_pkg::KICK_LEN_RST;
            r_len[1]    <= dsm_pkg::SNARE_LEN_RST;
            r_len[2]    <= dsm_pkg::HIHAT_LEN_RST;
            r_pos       <= '{default: '0};
            r_active    <= '0;
            r_prev      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (dsm_pkg::t_cfg_index'(i_cfg_index))
                    dsm_pkg::CFG_KICK_LEN:  r_len[0] <= i_cfg_data;
                    dsm_pkg::CFG_SNARE_LEN: r_len[1] <= i_cfg_data;
                    dsm_pkg::CFG_HIHAT_LEN: r_len[2] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_pos      <= n_pos;
            r_active   <= n_active;
            r_prev     <= n_prev;
            r_s1_valid <= n_s1_valid;
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_use <= n_s1_use;
        if (s1_adv && r_s1_valid) begin
            r_dac  <= dsm_pkg::CMD_BITS | {4'b0000, mix_level};
            r_clip <= mix_clip;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_dac_command = r_dac;
    assign o_clipped     = r_clip;

    a_tick_enters_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_opcode == dsm_pkg::OP_TICK) |=> r_s1_valid)
        else $error("tick transfer did not reach the read stage");

    a_s1_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_use))
        else $error("stalled read stage lost its item");

    a_cmd_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dac_command[15:12] == 4'b0111))
        else $error("DAC command bits wrong");

    a_clip_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |-> (o_dac_command[11:0] == dsm_pkg::MAX_LEVEL))
        else $error("clipped result not saturated");

endmodule
